### hdl/lfp_pkg.sv
// Shared types, constants and helper functions for the line-follow PID controller.
// Used by every module of the block; depends on nothing else.
package lfp_pkg;

   localparam int SENSOR_WIDTH = 8;
   localparam int SPEED_WIDTH = 16;
   localparam int STATUS_WIDTH = 3;
   localparam int TURN_WIDTH = 16;
   localparam int GAIN_WIDTH = 24;
   localparam int LIMIT_WIDTH = 8;
   localparam int ERR_WIDTH = 12;
   localparam int DERIV_WIDTH = 13;
   localparam int FRAC_BITS = 16;
   localparam int SUM_WIDTH = 64;

   // The integral is clamped to +/- 2^38 before the gain multiply.
   localparam int IVAL_CLAMP_SHIFT = 38;
   localparam int IVAL_WIDTH = 40;
   localparam int IVAL_LO_WIDTH = 20;
   localparam int IVAL_HI_WIDTH = IVAL_WIDTH - IVAL_LO_WIDTH;

   localparam int INTEGRAL_WIDTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KP_GAIN = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KI_GAIN = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KD_GAIN = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOST_LIMIT = 2'd3;

   localparam logic [GAIN_WIDTH-1:0] KP_GAIN_RESET = 24'd262144;
   localparam logic [GAIN_WIDTH-1:0] KI_GAIN_RESET = 24'd13;
   localparam logic [GAIN_WIDTH-1:0] KD_GAIN_RESET = 24'd98304;
   localparam logic [LIMIT_WIDTH-1:0] LOST_LIMIT_RESET = 8'd100;

   localparam logic [STATUS_WIDTH-1:0] ST_FOLLOW = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_ALL = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_LEFT = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_RIGHT = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] ST_LOST = 3'd4;

   localparam logic signed [ERR_WIDTH-1:0] LINE_WEIGHT [SENSOR_WIDTH] = '{
      12'sd1200, 12'sd420, 12'sd240, 12'sd60,
      -12'sd60, -12'sd240, -12'sd420, -12'sd1200
   };

   localparam logic signed [TURN_WIDTH-1:0] TURN_MAX = 16'sh7fff;
   localparam logic signed [TURN_WIDTH-1:0] TURN_MIN = 16'sh8000;

   // One classified item as it waits between the front and back ends.
   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic signed [ERR_WIDTH-1:0] err;
      logic signed [DERIV_WIDTH-1:0] deriv;
      logic [SPEED_WIDTH-1:0] speed;
   } lfp_entry_type;

   function automatic logic [2:0] count_nibble(input logic [3:0] bits);
      logic [2:0] n;
      n = 3'd0;
      for (int i = 0; i < 4; i++) begin
         n = n + {2'b00, bits[i]};
      end
      return n;
   endfunction

   function automatic logic signed [ERR_WIDTH-1:0] line_error(
      input logic [SENSOR_WIDTH-1:0] pat);
      logic signed [ERR_WIDTH-1:0] acc;
      acc = '0;
      for (int i = 0; i < SENSOR_WIDTH; i++) begin
         if (pat[i]) begin
            acc = acc + LINE_WEIGHT[i];
         end
      end
      return acc;
   endfunction

endpackage

### hdl/lfp_front.sv
// Front end: accepts sensor items, classifies them and updates the PID state.
// Depends on lfp_pkg; feeds lfp_queue.
module lfp_front
   import lfp_pkg::*;
#(
   parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [SENSOR_WIDTH-1:0] req_sensor_pattern,
   input  logic [SPEED_WIDTH-1:0] req_forward_speed,
   input  logic [LIMIT_WIDTH-1:0] lost_limit,
   input  logic queue_full,
   output logic push,
   output lfp_entry_type push_entry,
   output logic signed [INTEGRAL_WIDTH-1:0] push_integral
);

   localparam int ISUM_WIDTH = INTEGRAL_WIDTH + 1;
   localparam logic signed [INTEGRAL_WIDTH-1:0] IMAX = {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
   localparam logic signed [INTEGRAL_WIDTH-1:0] IMIN = {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};

   logic [LIMIT_WIDTH-1:0] lost_count_ff, lost_count_in;
   logic signed [INTEGRAL_WIDTH-1:0] integral_ff, integral_in;
   logic signed [ERR_WIDTH-1:0] prev_error_ff, prev_error_in;

   logic blank;
   logic lost_hit;
   logic [LIMIT_WIDTH-1:0] lost_inc;
   logic [2:0] left_count, right_count;
   logic [STATUS_WIDTH-1:0] status;
   logic follow;
   logic signed [ERR_WIDTH-1:0] err;
   logic signed [DERIV_WIDTH-1:0] deriv;
   logic signed [ISUM_WIDTH-1:0] isum;
   logic signed [INTEGRAL_WIDTH-1:0] integral_sat;

   assign req_ready = !queue_full;
   assign push = req_valid && req_ready;

   always_comb begin
      blank = (req_sensor_pattern == '0);
      lost_inc = lost_count_ff + 8'd1;
      lost_hit = blank && (lost_inc > lost_limit);
      left_count = count_nibble(req_sensor_pattern[7:4]);
      right_count = count_nibble(req_sensor_pattern[3:0]);

      priority if (lost_hit) begin
         status = ST_LOST;
      end else if (left_count > 3'd2 && right_count > 3'd2) begin
         status = ST_ALL;
      end else if (left_count > 3'd2 && right_count < 3'd2) begin
         status = ST_LEFT;
      end else if (left_count < 3'd2 && right_count > 3'd2) begin
         status = ST_RIGHT;
      end else begin
         status = ST_FOLLOW;
      end
      follow = (status == ST_FOLLOW);

      err = blank ? prev_error_ff : line_error(req_sensor_pattern);
      deriv = DERIV_WIDTH'(prev_error_ff) - DERIV_WIDTH'(err);

      isum = ISUM_WIDTH'(integral_ff) + ISUM_WIDTH'(err);
      if (isum[INTEGRAL_WIDTH] != isum[INTEGRAL_WIDTH-1]) begin
         integral_sat = isum[INTEGRAL_WIDTH] ? IMIN : IMAX;
      end else begin
         integral_sat = isum[INTEGRAL_WIDTH-1:0];
      end

      lost_count_in = lost_count_ff;
      integral_in = integral_ff;
      prev_error_in = prev_error_ff;
      if (push) begin
         lost_count_in = (blank && !lost_hit) ? lost_inc : '0;
         if (follow) begin
            integral_in = integral_sat;
            prev_error_in = err;
         end
      end

      // Items that are not followed carry zeros so the back end yields zero.
      push_entry.status = status;
      push_entry.err = follow ? err : '0;
      push_entry.deriv = follow ? deriv : '0;
      push_entry.speed = follow ? req_forward_speed : '0;
      push_integral = follow ? integral_sat : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lost_count_ff <= '0;
         integral_ff <= '0;
         prev_error_ff <= '0;
      end else begin
         lost_count_ff <= lost_count_in;
         integral_ff <= integral_in;
         prev_error_ff <= prev_error_in;
      end
   end

`ifndef SYNTH
   a_seen_clears_lost: assert property (@(posedge clock) disable iff (reset)
      push && !blank |=> lost_count_ff == '0)
      else $error("lost counter not cleared by a nonblank item");

   a_blank_counts: assert property (@(posedge clock) disable iff (reset)
      push && blank && !lost_hit |=> lost_count_ff == $past(lost_count_ff) + 8'd1)
      else $error("lost counter did not advance on a blank item");

   a_corner_keeps_state: assert property (@(posedge clock) disable iff (reset)
      push && !follow |=> $stable(integral_ff) && $stable(prev_error_ff))
      else $error("PID state changed on an item that is not followed");
`endif

endmodule

### hdl/lfp_queue.sv
// Short flip-flop queue between the front and back ends.
// Depends on lfp_pkg for its default depth.
module lfp_queue
   import lfp_pkg::*;
#(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic [DATA_WIDTH-1:0] push_data,
   output logic full,
   input  logic pop,
   output logic head_valid,
   output logic [DATA_WIDTH-1:0] head_data
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(DEPTH - 1);

   logic [DATA_WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   assign full = (count_ff == COUNT_WIDTH'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

### hdl/lfp_back.sv
// Back end: gain multiplies, sum, truncation and saturation, and the result register.
// Depends on lfp_pkg; takes items from lfp_queue.
module lfp_back
   import lfp_pkg::*;
#(
   parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic [GAIN_WIDTH-1:0] kp_gain,
   input  logic [GAIN_WIDTH-1:0] ki_gain,
   input  logic [GAIN_WIDTH-1:0] kd_gain,
   input  logic head_valid,
   input  lfp_entry_type head_entry,
   input  logic signed [INTEGRAL_WIDTH-1:0] head_integral,
   output logic pop,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [STATUS_WIDTH-1:0] rsp_line_status,
   output logic signed [TURN_WIDTH-1:0] rsp_turn_drive,
   output logic [SPEED_WIDTH-1:0] rsp_drive_speed
);

   localparam int IEXT_WIDTH = (INTEGRAL_WIDTH > IVAL_WIDTH) ? INTEGRAL_WIDTH : IVAL_WIDTH;
   localparam logic signed [IEXT_WIDTH-1:0] ICLAMP_POS =
      {{(IEXT_WIDTH-IVAL_CLAMP_SHIFT-1){1'b0}}, 1'b1, {IVAL_CLAMP_SHIFT{1'b0}}};
   localparam logic signed [IEXT_WIDTH-1:0] ICLAMP_NEG = -ICLAMP_POS;
   localparam int PERR_WIDTH = ERR_WIDTH + GAIN_WIDTH + 1;
   localparam int PDER_WIDTH = DERIV_WIDTH + GAIN_WIDTH + 1;
   localparam int PLO_WIDTH = IVAL_LO_WIDTH + GAIN_WIDTH + 2;
   localparam int PHI_WIDTH = IVAL_HI_WIDTH + GAIN_WIDTH + 1;
   localparam int Q_WIDTH = SUM_WIDTH - FRAC_BITS;

   // Stage 1: clamp and split the integral.
   logic s1_valid_ff;
   lfp_entry_type s1_entry_ff;
   logic [IVAL_LO_WIDTH-1:0] s1_ilo_ff;
   logic signed [IVAL_HI_WIDTH-1:0] s1_ihi_ff;
   // Stage 2: products.
   logic s2_valid_ff;
   logic [STATUS_WIDTH-1:0] s2_status_ff;
   logic [SPEED_WIDTH-1:0] s2_speed_ff;
   logic signed [PERR_WIDTH-1:0] s2_perr_ff;
   logic signed [PDER_WIDTH-1:0] s2_pder_ff;
   logic signed [PLO_WIDTH-1:0] s2_plo_ff;
   logic signed [PHI_WIDTH-1:0] s2_phi_ff;
   // Stage 3: full sum.
   logic s3_valid_ff;
   logic [STATUS_WIDTH-1:0] s3_status_ff;
   logic [SPEED_WIDTH-1:0] s3_speed_ff;
   logic signed [SUM_WIDTH-1:0] s3_sum_ff;
   // Result register.
   logic out_valid_ff;
   logic [STATUS_WIDTH-1:0] out_status_ff;
   logic signed [TURN_WIDTH-1:0] out_turn_ff;
   logic [SPEED_WIDTH-1:0] out_speed_ff;

   logic out_adv, s3_adv, s2_adv, s1_adv;
   logic signed [IEXT_WIDTH-1:0] iext;
   logic signed [IEXT_WIDTH-1:0] iclamp;
   logic signed [Q_WIDTH-1:0] q_shift;
   logic signed [Q_WIDTH-1:0] q_trunc;
   logic signed [TURN_WIDTH-1:0] turn_sat;

   assign out_adv = !out_valid_ff || rsp_ready;
   assign s3_adv = !s3_valid_ff || out_adv;
   assign s2_adv = !s2_valid_ff || s3_adv;
   assign s1_adv = !s1_valid_ff || s2_adv;
   assign pop = head_valid && s1_adv;

   always_comb begin
      iext = IEXT_WIDTH'(head_integral);
      if (iext > ICLAMP_POS) begin
         iclamp = ICLAMP_POS;
      end else if (iext < ICLAMP_NEG) begin
         iclamp = ICLAMP_NEG;
      end else begin
         iclamp = iext;
      end
   end

   // Division by 2^16 truncated toward zero, then clamp to the turn range.
   always_comb begin
      q_shift = $signed(s3_sum_ff[SUM_WIDTH-1:FRAC_BITS]);
      q_trunc = q_shift + Q_WIDTH'(s3_sum_ff[SUM_WIDTH-1] && (s3_sum_ff[FRAC_BITS-1:0] != '0));
      if (q_trunc > Q_WIDTH'(TURN_MAX)) begin
         turn_sat = TURN_MAX;
      end else if (q_trunc < Q_WIDTH'(TURN_MIN)) begin
         turn_sat = TURN_MIN;
      end else begin
         turn_sat = q_trunc[TURN_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_entry_ff <= head_entry;
         s1_ilo_ff <= iclamp[IVAL_LO_WIDTH-1:0];
         s1_ihi_ff <= iclamp[IVAL_WIDTH-1:IVAL_LO_WIDTH];
      end
      if (s2_adv) begin
         s2_status_ff <= s1_entry_ff.status;
         s2_speed_ff <= s1_entry_ff.speed;
         s2_perr_ff <= PERR_WIDTH'(s1_entry_ff.err) * PERR_WIDTH'($signed({1'b0, kp_gain}));
         s2_pder_ff <= PDER_WIDTH'(s1_entry_ff.deriv) * PDER_WIDTH'($signed({1'b0, kd_gain}));
         s2_plo_ff <= PLO_WIDTH'($signed({1'b0, s1_ilo_ff}))
                    * PLO_WIDTH'($signed({1'b0, ki_gain}));
         s2_phi_ff <= PHI_WIDTH'(s1_ihi_ff) * PHI_WIDTH'($signed({1'b0, ki_gain}));
      end
      if (s3_adv) begin
         s3_status_ff <= s2_status_ff;
         s3_speed_ff <= s2_speed_ff;
         s3_sum_ff <= SUM_WIDTH'(s2_perr_ff) + SUM_WIDTH'(s2_pder_ff)
                    + SUM_WIDTH'(s2_plo_ff) + (SUM_WIDTH'(s2_phi_ff) <<< IVAL_LO_WIDTH);
      end
      if (out_adv) begin
         out_status_ff <= s3_status_ff;
         out_turn_ff <= turn_sat;
         out_speed_ff <= s3_speed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) begin
            s1_valid_ff <= head_valid;
         end
         if (s2_adv) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_adv) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (out_adv) begin
            out_valid_ff <= s3_valid_ff;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_line_status = out_status_ff;
   assign rsp_turn_drive = out_turn_ff;
   assign rsp_drive_speed = out_speed_ff;

`ifndef SYNTH
   a_idle_result_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_status_ff != ST_FOLLOW |-> out_turn_ff == '0 && out_speed_ff == '0)
      else $error("non-following result carries a turn or a speed");
`endif

endmodule

### hdl/line_follow_pid_controller.sv
// Top level of the line-follow PID controller: configuration registers and wiring.
// Depends on lfp_pkg, lfp_front, lfp_queue and lfp_back.
//
// Usage: each item on the req_ channel carries one 8-bit reflectance pattern
// and a forward speed. The block answers every item with exactly one item on
// the rsp_ channel, in order: a line status, a PID turn command and the speed.
// The turn command and speed are zero unless the status is following.
// Gains and the lost limit are written through the csr_ channel, which is
// always ready; write it only while no item is in flight.
// One item is taken every cycle unless the queue is full; the front end
// updates the lost counter, integral and previous error registers as each
// item is accepted, and the back end is a four-stage pipeline of clamp, gain
// multiplies, sum and truncate/saturate.
// When the receiver stalls, results pile up in the pipeline and then in a
// short queue; req_ready drops only once that queue is full.
// Reset (synchronous, active high) clears the PID state and the lost counter,
// empties the queue and pipeline, and loads the default gains and limit.
module line_follow_pid_controller
   import lfp_pkg::*;
#(
   parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [SENSOR_WIDTH-1:0] req_sensor_pattern,
   input  logic [SPEED_WIDTH-1:0] req_forward_speed,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [STATUS_WIDTH-1:0] rsp_line_status,
   output logic signed [TURN_WIDTH-1:0] rsp_turn_drive,
   output logic [SPEED_WIDTH-1:0] rsp_drive_speed,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [GAIN_WIDTH-1:0] csr_data
);

   localparam int ENTRY_WIDTH = $bits(lfp_entry_type);
   localparam int QDATA_WIDTH = ENTRY_WIDTH + INTEGRAL_WIDTH;

   logic [GAIN_WIDTH-1:0] kp_gain_ff;
   logic [GAIN_WIDTH-1:0] ki_gain_ff;
   logic [GAIN_WIDTH-1:0] kd_gain_ff;
   logic [LIMIT_WIDTH-1:0] lost_limit_ff;

   logic push;
   logic queue_full;
   lfp_entry_type push_entry;
   logic signed [INTEGRAL_WIDTH-1:0] push_integral;
   logic pop;
   logic head_valid;
   logic [QDATA_WIDTH-1:0] head_data;
   lfp_entry_type head_entry;
   logic signed [INTEGRAL_WIDTH-1:0] head_integral;

   // Registers are plain writes; there is nothing to wait for.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_gain_ff <= KP_GAIN_RESET;
         ki_gain_ff <= KI_GAIN_RESET;
         kd_gain_ff <= KD_GAIN_RESET;
         lost_limit_ff <= LOST_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_KP_GAIN: begin
               kp_gain_ff <= csr_data;
            end
            CSR_KI_GAIN: begin
               ki_gain_ff <= csr_data;
            end
            CSR_KD_GAIN: begin
               kd_gain_ff <= csr_data;
            end
            CSR_LOST_LIMIT: begin
               lost_limit_ff <= csr_data[LIMIT_WIDTH-1:0];
            end
         endcase
      end
   end

   lfp_front #(
      .INTEGRAL_WIDTH(INTEGRAL_WIDTH)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sensor_pattern(req_sensor_pattern),
      .req_forward_speed(req_forward_speed),
      .lost_limit(lost_limit_ff),
      .queue_full(queue_full),
      .push(push),
      .push_entry(push_entry),
      .push_integral(push_integral)
   );

   // The queue carries the classified item together with the integral.
   lfp_queue #(
      .DATA_WIDTH(QDATA_WIDTH),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data({push_integral, push_entry}),
      .full(queue_full),
      .pop(pop),
      .head_valid(head_valid),
      .head_data(head_data)
   );

   assign head_entry = lfp_entry_type'(head_data[ENTRY_WIDTH-1:0]);
   assign head_integral = $signed(head_data[QDATA_WIDTH-1:ENTRY_WIDTH]);

   lfp_back #(
      .INTEGRAL_WIDTH(INTEGRAL_WIDTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .kp_gain(kp_gain_ff),
      .ki_gain(ki_gain_ff),
      .kd_gain(kd_gain_ff),
      .head_valid(head_valid),
      .head_entry(head_entry),
      .head_integral(head_integral),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_line_status(rsp_line_status),
      .rsp_turn_drive(rsp_turn_drive),
      .rsp_drive_speed(rsp_drive_speed)
   );

endmodule
